>>> src/prl_pkg.sv
// Shared types and codes for the positional record list.
`default_nettype none

package prl_pkg;

  // One stored record, first field in the highest bits.
  typedef struct packed {
    logic [15:0] id_high;
    logic [63:0] id_low;
    logic [63:0] title_first;
    logic [63:0] title_second;
    logic [31:0] title_third;
    logic [31:0] price;
  } record_t;

  // Per-item control that every cell sees in the accept cycle.
  typedef struct packed {
    logic       en;   // an item is accepted this cycle
    logic       ins;  // valid insert: open a slot at pos
    logic       del;  // valid delete: close the slot at pos
    logic [7:0] pos;  // one-based position of the item
  } cell_ctl_t;

  // Operation codes.
  localparam logic [2:0] OP_GET    = 3'd0;
  localparam logic [2:0] OP_LOCATE = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

>>> src/positional_record_list_core.sv
// Top level of the positional record list: control, cell chain and result register.
// The accepting edge shifts and compares in all cells at once and registers their match
// and select flags; the busy state takes no new item, runs the priority pick across
// all cells and loads the result once the output register is free.
// A waiting result does not block the next item unless a second result is ready.
// Reset clears the record count and the handshake state; stored records stay undefined.
`default_nettype none

module positional_record_list_core #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // position, in_id_high, in_id_low, in_title_first, in_title_second,
  // in_title_third, in_price (from bit 0 up)
  input  wire  [279:0] s_axis_tdata,
  // kind
  input  wire  [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // found_position, out_id_high, out_id_low, out_title_first, out_title_second,
  // out_title_third, out_price, fill_level (from bit 0 up)
  output logic [287:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 8) ? CW : 8;
  localparam int unsigned IW = $clog2(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic                                state_q, state_d;
  logic [CW-1:0]                       count_q, count_d;
  logic [1:0]                          status_q, status_d;
  logic                                get_q, get_d;
  logic                                loc_q, loc_d;
  logic                                accept;
  logic                                ins_ok, del_ok;
  logic                                pos_bad, ins_bad, full;
  logic [2:0]                          kind;
  logic [7:0]                          pos;
  logic [PW-1:0]                       pos_ext, cnt_ext;
  prl_pkg::record_t                    new_rec;
  prl_pkg::cell_ctl_t                  ctl;
  prl_pkg::record_t [CAPACITY-1:0]     recs;
  logic [CAPACITY-1:0]                 match;
  logic [CAPACITY-1:0]                 sel;
  logic                                hit;
  logic [IW-1:0]                       hit_index;
  logic [IW:0]                         hit_pos;
  prl_pkg::record_t                    sel_rec;
  logic                                load;
  logic                                out_valid_q;
  logic [1:0]                          out_status_q;
  logic [7:0]                          out_found_q;
  logic [7:0]                          out_fill_q;
  prl_pkg::record_t                    out_rec_q;

  // Input item fields.
  assign kind                 = s_axis_tuser;
  assign pos                  = s_axis_tdata[7:0];
  assign new_rec.id_high      = s_axis_tdata[23:8];
  assign new_rec.id_low       = s_axis_tdata[87:24];
  assign new_rec.title_first  = s_axis_tdata[151:88];
  assign new_rec.title_second = s_axis_tdata[215:152];
  assign new_rec.title_third  = s_axis_tdata[247:216];
  assign new_rec.price        = s_axis_tdata[279:248];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Range checks against the current count.
  assign pos_ext = PW'(pos);
  assign cnt_ext = PW'(count_q);
  assign full    = (count_q == CW'(CAPACITY));
  assign pos_bad = (pos == 8'd0) || (pos_ext > cnt_ext);
  assign ins_bad = (pos == 8'd0) || (pos_ext > PW'(cnt_ext + PW'(1)));

  // Decode the operation and work out its status and the new count.
  always_comb begin
    status_d = prl_pkg::ST_OK;
    count_d  = count_q;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    get_d    = 1'b0;
    loc_d    = 1'b0;
    case (kind)
      prl_pkg::OP_GET: begin
        if (pos_bad) begin
          status_d = prl_pkg::ST_BADPOS;
        end else begin
          get_d = 1'b1;
        end
      end
      prl_pkg::OP_LOCATE: begin
        loc_d = 1'b1;
      end
      prl_pkg::OP_INSERT: begin
        if (full) begin
          status_d = prl_pkg::ST_FULL;
        end else if (ins_bad) begin
          status_d = prl_pkg::ST_BADPOS;
        end else begin
          ins_ok  = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      prl_pkg::OP_DELETE: begin
        if (pos_bad) begin
          status_d = prl_pkg::ST_BADPOS;
        end else begin
          del_ok  = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      prl_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign ctl.en  = accept;
  assign ctl.ins = ins_ok;
  assign ctl.del = del_ok;
  assign ctl.pos = pos;

  // The chain of cells; the first cell takes the new record on its left, the last feeds itself on its right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    prl_pkg::record_t left_rec, right_rec;
    if (i == 0) begin : g_first
      assign left_rec = new_rec;
    end else begin : g_mid_l
      assign left_rec = recs[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_rec = recs[i];
    end else begin : g_mid_r
      assign right_rec = recs[i+1];
    end
    prl_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .new_i   (new_rec),
      .left_i  (left_rec),
      .right_i (right_rec),
      .price_i (new_rec.price),
      .count_i (cnt_ext),
      .rec_o   (recs[i]),
      .match_o (match[i]),
      .sel_o   (sel[i])
    );
  end

  prl_pick #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_pick (
    .match_i (match),
    .sel_i   (sel),
    .recs_i  (recs),
    .hit_o   (hit),
    .index_o (hit_index),
    .rec_o   (sel_rec)
  );

  assign hit_pos = {1'b0, hit_index} + (IW + 1)'(1);

  // Move the result into the output register once it is free.
  assign load = (state_q == S_BUSY) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      status_q    <= prl_pkg::ST_OK;
      get_q       <= 1'b0;
      loc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_q  <= count_d;
        status_q <= status_d;
        get_q    <= get_d;
        loc_q    <= loc_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_fill_q <= 8'(count_q);
      out_rec_q  <= get_q ? sel_rec : '0;
      if (loc_q) begin
        out_status_q <= hit ? prl_pkg::ST_OK : prl_pkg::ST_NOTFOUND;
        out_found_q  <= hit ? 8'(hit_pos) : 8'd0;
      end else begin
        out_status_q <= status_q;
        out_found_q  <= 8'd0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_fill_q,
                          out_rec_q.price,
                          out_rec_q.title_third,
                          out_rec_q.title_second,
                          out_rec_q.title_first,
                          out_rec_q.id_low,
                          out_rec_q.id_high,
                          out_found_q};

  // An accepted item always moves the control into its result cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_BUSY))
    else $error("accepted item did not start its result cycle");

  // The record count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("record count beyond capacity");

  // A new result only appears right after a result cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_BUSY))
    else $error("result appeared without an item");

  // The count changes only on an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(accept) |-> $stable(count_q))
    else $error("record count changed without an item");

endmodule

`default_nettype wire

>>> src/prl_cell.sv
// One list cell: holds a record, shifts with its neighbors and flags a match.
`default_nettype none

module prl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 8
) (
  input  wire                   clk_i,
  input  wire prl_pkg::cell_ctl_t ctl_i,
  input  wire prl_pkg::record_t new_i,
  input  wire prl_pkg::record_t left_i,
  input  wire prl_pkg::record_t right_i,
  input  wire  [31:0]           price_i,
  input  wire  [PW-1:0]         count_i,
  output prl_pkg::record_t      rec_o,
  output logic                  match_o,
  output logic                  sel_o
);

  // One-based position of this cell.
  localparam logic [PW-1:0] MY_POS = PW'(IDX + 1);

  prl_pkg::record_t rec_q, rec_d;
  logic             match_q, match_d;
  logic             sel_q, sel_d;
  logic [PW-1:0]    pos_ext;

  assign pos_ext = PW'(ctl_i.pos);

  // Shift toward higher positions on insert, toward lower ones on delete.
  always_comb begin
    rec_d   = rec_q;
    match_d = match_q;
    sel_d   = sel_q;
    if (ctl_i.en) begin
      match_d = (rec_q.price == price_i) && (MY_POS <= count_i);
      sel_d   = (MY_POS == pos_ext);
      if (ctl_i.ins) begin
        if (MY_POS > pos_ext) begin
          rec_d = left_i;
        end else if (MY_POS == pos_ext) begin
          rec_d = new_i;
        end
      end else if (ctl_i.del) begin
        if (MY_POS >= pos_ext) begin
          rec_d = right_i;
        end
      end
    end
  end

  // Record contents are undefined until written, so no reset.
  always_ff @(posedge clk_i) begin
    rec_q   <= rec_d;
    match_q <= match_d;
    sel_q   <= sel_d;
  end

  assign rec_o   = rec_q;
  assign match_o = match_q;
  assign sel_o   = sel_q;

endmodule

`default_nettype wire

>>> src/prl_pick.sv
// Priority pick of the first matching cell and read-out of the selected cell.
`default_nettype none

module prl_pick #(
  parameter int unsigned N  = 128,
  parameter int unsigned IW = 7
) (
  input  wire              [N-1:0]  match_i,
  input  wire              [N-1:0]  sel_i,
  input  wire prl_pkg::record_t [N-1:0] recs_i,
  output logic                      hit_o,
  output logic             [IW-1:0] index_o,
  output prl_pkg::record_t          rec_o
);

  logic [N-1:0] first;

  // Isolate the lowest set match bit.
  assign first = match_i & (~match_i + N'(1));
  assign hit_o = |match_i;

  // Encode the one-hot match and mux the one-hot selected record.
  always_comb begin
    index_o = '0;
    rec_o   = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        index_o = index_o | IW'(i);
      end
      if (sel_i[i]) begin
        rec_o = rec_o | recs_i[i];
      end
    end
  end

endmodule

`default_nettype wire
